### rtl/text_terminal_writer_core_assert.svh
// Assertion macros used by the text terminal writer controller.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef TEXT_TERMINAL_WRITER_CORE_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TTW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("text_terminal_writer_core: assertion failed");
`define TTW_ASSERT_NEVER(label, clk, rst, cond) `TTW_ASSERT(label, clk, rst, !(cond))
`else
`define TTW_ASSERT(label, clk, rst, prop)
`define TTW_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

### rtl/ttw_pkg.sv
// Types and constants of the text terminal writer: field widths, command codes,
// character codes and the controller to datapath command and status structs.
// Depends on nothing.
package ttw_pkg;

   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int CELL_W     = 16;
   localparam int ROW_PORT_W = 5;
   localparam int COL_PORT_W = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_PUT        = 2'd0;
   localparam cmd_type CMD_SET_CURSOR = 2'd1;
   localparam cmd_type CMD_READ       = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;

   // Register index as seen in bit 2 of the byte address.
   localparam logic REG_TEXT_COLOR = 1'b0;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic exec;
      logic fill_step;
      logic take_read;
   } ctl_type;

   typedef struct packed {
      logic clear_done;
      logic fill_done;
      logic scroll;
      logic is_read;
   } sts_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                   input logic [ATTR_W-1:0] attr);
      return {attr, ch};
   endfunction

endpackage

### rtl/ttw_datapath.sv
// Datapath of the text terminal writer: screen memory, cursor, scroll offset,
// clear and fill counters. Depends on ttw_pkg; driven by ttw_ctrl.
module ttw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ttw_pkg::ctl_type                  ctl,
   output ttw_pkg::sts_type                  sts,
   input  logic [ttw_pkg::CMD_W-1:0]         req_command,
   input  logic [ttw_pkg::CHAR_W-1:0]        req_character,
   input  logic [ttw_pkg::ROW_PORT_W-1:0]    req_target_row,
   input  logic [ttw_pkg::COL_PORT_W-1:0]    req_target_col,
   input  logic [ttw_pkg::ATTR_W-1:0]        text_color,
   output logic [ttw_pkg::CELL_W-1:0]        rsp_cell_data,
   output logic [ttw_pkg::ROW_PORT_W-1:0]    rsp_cursor_row_now,
   output logic [ttw_pkg::COL_PORT_W-1:0]    rsp_cursor_col_now
);

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   logic [ttw_pkg::CELL_W-1:0] screen_ff [CELLS];
   logic [ttw_pkg::CELL_W-1:0] rdata_ff;
   logic [ttw_pkg::CELL_W-1:0] cell_data_ff;

   ttw_pkg::cmd_type            cmd_ff;
   logic [ttw_pkg::CHAR_W-1:0]  char_ff;
   logic [ROW_W-1:0]            trow_ff;
   logic [COL_W-1:0]            tcol_ff;

   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic [COL_W-1:0]  fill_col_ff, fill_col_in;

   logic                       is_newline;
   logic                       advance;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ttw_pkg::CELL_W-1:0] wr_data;

   // The screen is a ring of rows; top_ff is the physical row shown at the top.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] row);
      logic [ROW_W:0] sum;
      sum = {1'b0, top} + {1'b0, row};
      if (sum >= (ROW_W + 1)'(ROWS)) begin
         sum = sum - (ROW_W + 1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
   endfunction

   assign is_newline = (char_ff == ttw_pkg::NEWLINE_CHAR);
   assign advance    = (cmd_ff == ttw_pkg::CMD_PUT) &&
                       (is_newline || (cursor_col_ff == LAST_COL));

   assign sts.clear_done = (clear_addr_ff == LAST_ADDR);
   assign sts.fill_done  = (fill_col_ff == LAST_COL);
   assign sts.scroll     = advance && (cursor_row_ff == LAST_ROW);
   assign sts.is_read    = (cmd_ff == ttw_pkg::CMD_READ);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clear_addr_ff;
      wr_data = ttw_pkg::make_cell(ttw_pkg::BLANK_CHAR, ttw_pkg::RESET_COLOR);
      if (ctl.clear_step) begin
         wr_en = 1'b1;
      end else if (ctl.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = cell_addr(phys_row(top_ff, LAST_ROW), fill_col_ff);
         wr_data = ttw_pkg::make_cell(ttw_pkg::BLANK_CHAR, text_color);
      end else if (ctl.exec && (cmd_ff == ttw_pkg::CMD_PUT) && !is_newline) begin
         wr_en   = 1'b1;
         wr_addr = cell_addr(phys_row(top_ff, cursor_row_ff), cursor_col_ff);
         wr_data = ttw_pkg::make_cell(char_ff, text_color);
      end
   end

   assign rd_addr = cell_addr(phys_row(top_ff, trow_ff), tcol_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= screen_ff[rd_addr];
   end

   always_comb begin
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      top_in        = top_ff;
      if (ctl.exec) begin
         case (cmd_ff)
            ttw_pkg::CMD_PUT: begin
               if (advance) begin
                  cursor_col_in = '0;
                  if (cursor_row_ff == LAST_ROW) begin
                     top_in = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                  end else begin
                     cursor_row_in = cursor_row_ff + 1'b1;
                  end
               end else begin
                  cursor_col_in = cursor_col_ff + 1'b1;
               end
            end
            ttw_pkg::CMD_SET_CURSOR: begin
               cursor_row_in = trow_ff;
               cursor_col_in = tcol_ff;
            end
            default: begin
               cursor_row_in = cursor_row_ff;
            end
         endcase
      end
      clear_addr_in = ctl.clear_step ? clear_addr_ff + 1'b1 : clear_addr_ff;
      fill_col_in   = fill_col_ff;
      if (ctl.fill_step) begin
         fill_col_in = sts.fill_done ? '0 : fill_col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         top_ff        <= '0;
         clear_addr_ff <= '0;
         fill_col_ff   <= '0;
      end else begin
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         top_ff        <= top_in;
         clear_addr_ff <= clear_addr_in;
         fill_col_ff   <= fill_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_command;
         char_ff <= req_character;
         trow_ff <= (req_target_row > ttw_pkg::ROW_PORT_W'(ROWS - 1)) ?
                    LAST_ROW : req_target_row[ROW_W-1:0];
         tcol_ff <= (req_target_col > ttw_pkg::COL_PORT_W'(COLUMNS - 1)) ?
                    LAST_COL : req_target_col[COL_W-1:0];
      end
      if (ctl.exec) begin
         cell_data_ff <= '0;
      end else if (ctl.take_read) begin
         cell_data_ff <= rdata_ff;
      end
   end

   assign rsp_cell_data      = cell_data_ff;
   assign rsp_cursor_row_now = ttw_pkg::ROW_PORT_W'(cursor_row_ff);
   assign rsp_cursor_col_now = ttw_pkg::COL_PORT_W'(cursor_col_ff);

endmodule

### rtl/ttw_ctrl.sv
// Controller of the text terminal writer: sequences the clearing pass,
// command execution, cell reads and scroll fills. Depends on ttw_pkg.
`include "text_terminal_writer_core_assert.svh"

module ttw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output ttw_pkg::ctl_type ctl,
   input  ttw_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RDWAIT,
      ST_FILL
   } state_type;

   state_type state_ff;
   logic      rsp_strobe_ff;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

   assign ctl.clear_step = (state_ff == ST_CLEAR);
   assign ctl.load       = (state_ff == ST_IDLE) && start;
   assign ctl.exec       = (state_ff == ST_EXEC);
   assign ctl.fill_step  = (state_ff == ST_FILL);
   assign ctl.take_read  = (state_ff == ST_RDWAIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               if (sts.clear_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (sts.is_read) begin
                  state_ff <= ST_RDWAIT;
               end else if (sts.scroll) begin
                  state_ff <= ST_FILL;
               end else begin
                  state_ff      <= ST_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end
            end
            ST_RDWAIT: begin
               state_ff      <= ST_IDLE;
               rsp_strobe_ff <= 1'b1;
            end
            ST_FILL: begin
               if (sts.fill_done) begin
                  state_ff      <= ST_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   `TTW_ASSERT(a_accept_exec, clock, reset, (start && !busy) |=> (state_ff == ST_EXEC))
   `TTW_ASSERT_NEVER(a_strobe_busy, clock, reset, rsp_strobe && busy)
   `TTW_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `TTW_ASSERT(a_fill_exit, clock, reset,
      (state_ff == ST_FILL) |=> ((state_ff == ST_FILL) || (state_ff == ST_IDLE)))

endmodule

### rtl/text_terminal_writer_core.sv
// Top level of the text terminal writer: command channel, result channel and
// the register port. Depends on ttw_pkg, ttw_ctrl and ttw_datapath.
//
// Usage: keep start high with req_command, req_character, req_target_row and
// req_target_col valid; the item is taken at the edge where start is high and
// busy is low. Commands are put character, set cursor and read cell. Every
// item yields one result on rsp_cell_data, rsp_cursor_row_now and
// rsp_cursor_col_now, shown for one cycle with rsp_strobe high.
// Sequence: put, set cursor and unused codes pass through ST_EXEC, a read
// through ST_EXEC and ST_RDWAIT, and a put that scrolls through ST_EXEC and
// ST_FILL, in which the new bottom line is filled one cell per cycle; the
// strobe rises as the controller returns to ST_IDLE. busy drops when the
// strobe rises, so a new item can be taken once the last result is shown.
// Reset clears the cursor and sets text_color to 0x07; afterwards a clearing
// pass writes blanks to all ROWS * COLUMNS cells while busy stays high.
// Register writes are taken at any time.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module text_terminal_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ttw_pkg::CMD_W-1:0]         req_command,
   input  logic [ttw_pkg::CHAR_W-1:0]        req_character,
   input  logic [ttw_pkg::ROW_PORT_W-1:0]    req_target_row,
   input  logic [ttw_pkg::COL_PORT_W-1:0]    req_target_col,
   output logic                              rsp_strobe,
   output logic [ttw_pkg::CELL_W-1:0]        rsp_cell_data,
   output logic [ttw_pkg::ROW_PORT_W-1:0]    rsp_cursor_row_now,
   output logic [ttw_pkg::COL_PORT_W-1:0]    rsp_cursor_col_now,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ttw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ttw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ttw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   ttw_pkg::ctl_type            ctl;
   ttw_pkg::sts_type            sts;
   logic [ttw_pkg::ATTR_W-1:0]  text_color_ff;
   logic                        color_wr;

   assign pready   = 1'b1;
   assign color_wr = psel && penable && pwrite && (paddr[2] == ttw_pkg::REG_TEXT_COLOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= ttw_pkg::RESET_COLOR;
      end else if (color_wr) begin
         text_color_ff <= pwdata[ttw_pkg::ATTR_W-1:0];
      end
   end

   assign prdata = (paddr[2] == ttw_pkg::REG_TEXT_COLOR) ?
                   ttw_pkg::CSR_DATA_W'(text_color_ff) : '0;

   ttw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl        (ctl),
      .sts        (sts)
   );

   ttw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_command),
      .req_character      (req_character),
      .req_target_row     (req_target_row),
      .req_target_col     (req_target_col),
      .text_color         (text_color_ff),
      .rsp_cell_data      (rsp_cell_data),
      .rsp_cursor_row_now (rsp_cursor_row_now),
      .rsp_cursor_col_now (rsp_cursor_col_now)
   );

endmodule
